// ===== rtl/swaf_pkg.sv =====
package swaf_pkg;

  localparam int MAX_PATTERN = 1024;
  localparam int ALPHABET    = 26;
  localparam int INDEX_WIDTH = 16;

  localparam int LETTER_W = 5;
  localparam int PTR_W    = $clog2(MAX_PATTERN);
  localparam int LEN_W    = $clog2(MAX_PATTERN + 1);
  localparam int CNT_W    = 12;
  localparam int TALLY_W  = 5;

  localparam logic [LETTER_W-1:0] ALPHA_LIMIT = LETTER_W'(ALPHABET);
  localparam logic [LEN_W-1:0]    LEN_MAX     = LEN_W'(MAX_PATTERN);
  localparam logic [PTR_W-1:0]    PTR_LAST    = PTR_W'(MAX_PATTERN - 1);
  localparam logic [INDEX_WIDTH-1:0] INDEX_MAX = '1;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_PATTERN = 2'd1,
    OP_TEXT    = 2'd2
  } op_t;

  // one update of the count bank
  typedef struct packed {
    logic                clear;
    logic                pat_en;    // pattern letter, already range checked
    logic                text_en;   // text letter, any code
    logic [LETTER_W-1:0] ch;
    logic                leave_en;  // letter leaving the window, in range
    logic [LETTER_W-1:0] leaving;
  } tally_cmd_t;

endpackage

// ===== rtl/sliding_window_anagram_finder.sv =====
// Channel   Dir  Beat fields (tdata, low bit first)
// s_axis    in   op[1:0], letter[6:2], zero pad to 8 bits
// m_axis    out  match[0], start_index[16:1], zero pad to 24 bits
//
// One beat per cycle unless a text beat waits on a stalled result; results are registered.
// Clear, pattern and unused-op beats give no result; each text beat gives one.
// The letter leaving the window is read from the ring the cycle the beat is
// taken, so it is ready when the beat reaches the count bank.
// rst is synchronous; no clearing pass, the ring is only read where written.
// A stalled result holds only text beats; other beats keep flowing past it.
module sliding_window_anagram_finder
  import swaf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // op[1:0], letter[6:2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // match[0], start_index[16:1]
);

  // input register
  logic                a_valid;
  logic [1:0]          a_op;
  logic [LETTER_W-1:0] a_letter;

  // control state
  logic [LEN_W-1:0]       pattern_length, pattern_length_next;
  logic [LEN_W-1:0]       window_fill, window_fill_next;
  logic [INDEX_WIDTH-1:0] text_position, text_position_next;
  logic                   text_started, text_started_next;
  logic [PTR_W-1:0]       write_ptr, write_ptr_next;

  // result register
  logic                   o_valid;
  logic                   o_match;
  logic [INDEX_WIDTH-1:0] o_index;

  logic                is_text;
  logic                advance;
  logic                s_accept;
  logic [LEN_W-1:0]    fill_inc;
  logic                overflow;
  logic [LETTER_W-1:0] ring_q;
  logic [LETTER_W-1:0] leaving;
  logic                ring_we;
  logic [LEN_W:0]      rd_sum;
  logic [PTR_W-1:0]    rd_addr;
  tally_cmd_t          cmd;
  logic                tally_match;

  assign is_text       = a_op == OP_TEXT;
  assign advance       = a_valid && (!is_text || !o_valid || m_axis_tready);
  assign s_axis_tready = !a_valid || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = {7'd0, o_index, o_match};

  always_comb begin
    pattern_length_next = pattern_length;
    window_fill_next    = window_fill;
    text_position_next  = text_position;
    text_started_next   = text_started;
    write_ptr_next      = write_ptr;
    ring_we             = 1'b0;
    cmd                 = '0;
    cmd.ch              = a_letter;

    fill_inc = window_fill + LEN_W'(1);
    overflow = fill_inc > pattern_length;
    leaving  = (pattern_length == '0) ? a_letter : ring_q;

    if (advance) begin
      unique case (a_op)
        OP_CLEAR: begin
          cmd.clear           = 1'b1;
          pattern_length_next = '0;
          window_fill_next    = '0;
          text_position_next  = '0;
          text_started_next   = 1'b0;
          write_ptr_next      = '0;
        end
        OP_PATTERN: begin
          if (!text_started && (pattern_length < LEN_MAX) && (a_letter < ALPHA_LIMIT)) begin
            cmd.pat_en          = 1'b1;
            pattern_length_next = pattern_length + LEN_W'(1);
          end
        end
        OP_TEXT: begin
          cmd.text_en       = 1'b1;
          text_started_next = 1'b1;
          ring_we           = 1'b1;
          write_ptr_next    = (write_ptr == PTR_LAST) ? '0 : write_ptr + PTR_W'(1);
          if (overflow) begin
            cmd.leave_en     = leaving < ALPHA_LIMIT;
            cmd.leaving      = leaving;
            window_fill_next = window_fill;
            if (text_position != INDEX_MAX) begin
              text_position_next = text_position + INDEX_WIDTH'(1);
            end
          end else begin
            window_fill_next = fill_inc;
          end
        end
        default: begin
        end
      endcase
    end

    // slot of the letter that leaves when the next beat arrives
    rd_sum = {1'b0, LEN_W'(write_ptr_next)} + (LEN_W + 1)'(MAX_PATTERN)
           - {1'b0, pattern_length_next};
    if (rd_sum >= (LEN_W + 1)'(MAX_PATTERN)) begin
      rd_addr = PTR_W'(rd_sum - (LEN_W + 1)'(MAX_PATTERN));
    end else begin
      rd_addr = PTR_W'(rd_sum);
    end
  end

  swaf_ring u_ring (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (write_ptr),
    .wr_data (a_letter),
    .rd_en   (s_accept),
    .rd_addr (rd_addr),
    .rd_data (ring_q)
  );

  swaf_tally u_tally (
    .clk   (clk),
    .rst   (rst),
    .en    (advance),
    .cmd   (cmd),
    .match (tally_match)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid        <= 1'b0;
      o_valid        <= 1'b0;
      pattern_length <= '0;
      window_fill    <= '0;
      text_position  <= '0;
      text_started   <= 1'b0;
      write_ptr      <= '0;
    end else begin
      pattern_length <= pattern_length_next;
      window_fill    <= window_fill_next;
      text_position  <= text_position_next;
      text_started   <= text_started_next;
      write_ptr      <= write_ptr_next;

      if (s_accept) begin
        a_valid <= 1'b1;
      end else if (advance) begin
        a_valid <= 1'b0;
      end

      if (advance && is_text) begin
        o_valid <= 1'b1;
      end else if (m_axis_tready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      a_op     <= s_axis_tdata[1:0];
      a_letter <= s_axis_tdata[6:2];
    end
    if (advance && is_text) begin
      o_match <= tally_match;
      o_index <= text_position_next;
    end
  end

endmodule

// ===== rtl/swaf_ring.sv =====
module swaf_ring
  import swaf_pkg::*;
(
  input  logic                clk,
  input  logic                wr_en,
  input  logic [PTR_W-1:0]    wr_addr,
  input  logic [LETTER_W-1:0] wr_data,
  input  logic                rd_en,
  input  logic [PTR_W-1:0]    rd_addr,
  output logic [LETTER_W-1:0] rd_data
);

  logic [LETTER_W-1:0] mem [MAX_PATTERN];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // write-first on a same-cycle address hit
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

// ===== rtl/swaf_tally.sv =====
module swaf_tally
  import swaf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  tally_cmd_t cmd,
  output logic       match
);

  logic signed [CNT_W-1:0] counts      [ALPHABET];
  logic signed [CNT_W-1:0] counts_next [ALPHABET];
  logic [TALLY_W-1:0]      distinct_total;
  logic [TALLY_W-1:0]      distinct_total_next;
  logic [TALLY_W-1:0]      satisfied_count;
  logic [TALLY_W-1:0]      satisfied_count_next;

  logic                    ch_ok;
  logic                    dec_en;
  logic signed [CNT_W-1:0] c_ch;
  logic signed [CNT_W-1:0] c_dec;
  logic signed [CNT_W-1:0] c_leave;
  logic [TALLY_W-1:0]      sat_mid;

  always_comb begin
    ch_ok   = cmd.ch < ALPHA_LIMIT;
    dec_en  = cmd.text_en && ch_ok;
    c_ch    = ch_ok ? counts[cmd.ch] : '0;
    c_dec   = c_ch - CNT_W'(1);
    // the leaving letter sees the decrement when it is the same letter
    c_leave = (dec_en && (cmd.leaving == cmd.ch)) ? c_dec
            : ((cmd.leaving < ALPHA_LIMIT) ? counts[cmd.leaving] : '0);

    sat_mid = satisfied_count + TALLY_W'(dec_en && (c_dec == '0));
    satisfied_count_next = sat_mid - TALLY_W'(cmd.leave_en && (c_leave == '0));
    distinct_total_next  = distinct_total + TALLY_W'(cmd.pat_en && (c_ch == '0));

    for (int i = 0; i < ALPHABET; i++) begin
      counts_next[i] = counts[i];
      if (cmd.pat_en && (cmd.ch == LETTER_W'(i))) begin
        counts_next[i] = c_ch + CNT_W'(1);
      end
      if (dec_en && (cmd.ch == LETTER_W'(i))) begin
        counts_next[i] = c_dec;
      end
      if (cmd.leave_en && (cmd.leaving == LETTER_W'(i))) begin
        counts_next[i] = c_leave + CNT_W'(1);
      end
    end

    match = satisfied_count_next == distinct_total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ALPHABET; i++) begin
        counts[i] <= '0;
      end
      distinct_total  <= '0;
      satisfied_count <= '0;
    end else if (en) begin
      if (cmd.clear) begin
        for (int i = 0; i < ALPHABET; i++) begin
          counts[i] <= '0;
        end
        distinct_total  <= '0;
        satisfied_count <= '0;
      end else begin
        for (int i = 0; i < ALPHABET; i++) begin
          counts[i] <= counts_next[i];
        end
        distinct_total  <= distinct_total_next;
        satisfied_count <= satisfied_count_next;
      end
    end
  end

endmodule

// ===== verif/sliding_window_anagram_finder_tb.sv =====
`timescale 1ns / 100ps

module sliding_window_anagram_finder_tb;
  import swaf_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int MAX_REPORTS = 40;
  localparam int WRAP_PAT_LEN = 48;

  typedef struct {
    logic [1:0]          op;
    logic [LETTER_W-1:0] letter;
  } beat_t;

  typedef struct {
    logic                   match;
    logic [INDEX_WIDTH-1:0] start_index;
  } window_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // op[1:0], letter[6:2]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // match[0], start_index[16:1]

  sliding_window_anagram_finder i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  beat_t   pending_beats[$];
  window_t expected_windows[$];
  beat_t   on_bus;

  // shadow of the search state
  int                  tally[ALPHABET];
  logic [LETTER_W-1:0] ring[MAX_PATTERN];
  int                  pat_len, distinct, satisfied, fill, win_start, wr_ptr;
  bit                  text_seen;

  int fail_count    = 0;
  int beats_taken   = 0;
  int results_seen  = 0;
  int matches_seen  = 0;

  function automatic void anagram_predict(input beat_t b);
    logic [LETTER_W-1:0] outgoing;
    window_t w;
    if (b.op == OP_CLEAR) begin
      foreach (tally[i]) tally[i] = 0;
      pat_len = 0;
      distinct = 0;
      satisfied = 0;
      fill = 0;
      win_start = 0;
      wr_ptr = 0;
      text_seen = 1'b0;
    end else if (b.op == OP_PATTERN) begin
      if (!text_seen && pat_len < MAX_PATTERN && b.letter < ALPHABET) begin
        if (tally[b.letter] == 0) distinct++;
        tally[b.letter]++;
        pat_len++;
      end
    end else if (b.op == OP_TEXT) begin
      text_seen = 1'b1;
      // empty pattern: the new letter leaves again at once
      outgoing = (pat_len == 0) ? b.letter
                                : ring[(wr_ptr + MAX_PATTERN - pat_len) % MAX_PATTERN];
      ring[wr_ptr] = b.letter;
      wr_ptr = (wr_ptr + 1) % MAX_PATTERN;
      if (b.letter < ALPHABET) begin
        tally[b.letter]--;
        if (tally[b.letter] == 0) satisfied++;
      end
      fill++;
      if (fill > pat_len) begin
        if (outgoing < ALPHABET) begin
          if (tally[outgoing] == 0) satisfied--;
          tally[outgoing]++;
        end
        fill--;
        if (win_start < INDEX_MAX) win_start++;
      end
      w.match = (satisfied == distinct);
      w.start_index = win_start[INDEX_WIDTH-1:0];
      expected_windows = {expected_windows, w};
    end
  endfunction

  function automatic void push_beat(input logic [1:0] op, input logic [LETTER_W-1:0] letter);
    beat_t b;
    b.op = op;
    b.letter = letter;
    pending_beats = {pending_beats, b};
  endfunction

  function automatic void build_directed();
    // reset state: empty pattern, every text letter matches
    push_beat(OP_TEXT, 5'd0);
    push_beat(OP_TEXT, 5'd31);
    push_beat(OP_UNUSED, 5'd31);
    push_beat(OP_CLEAR, 5'd17);
    push_beat(OP_PATTERN, 5'd0);
    push_beat(OP_PATTERN, 5'd25);
    push_beat(OP_PATTERN, 5'd26);   // outside alphabet, dropped
    push_beat(OP_PATTERN, 5'd31);
    push_beat(OP_PATTERN, 5'd0);
    push_beat(OP_TEXT, 5'd25);
    push_beat(OP_TEXT, 5'd0);
    push_beat(OP_TEXT, 5'd0);
    push_beat(OP_TEXT, 5'd31);      // poisons three windows
    push_beat(OP_PATTERN, 5'd1);    // too late, dropped
    push_beat(OP_TEXT, 5'd0);
    push_beat(OP_UNUSED, 5'd0);
    push_beat(OP_TEXT, 5'd25);
    push_beat(OP_TEXT, 5'd0);
    push_beat(OP_TEXT, 5'd0);
    push_beat(OP_CLEAR, 5'd0);
    push_beat(OP_TEXT, 5'd25);
    push_beat(OP_TEXT, 5'd26);
  endfunction

  // text run longer than the ring since the last clear, so the write pointer wraps
  function automatic void build_ring_wrap();
    int k, j, swap_at;
    logic [LETTER_W-1:0] pat[$];
    logic [LETTER_W-1:0] perm[$];
    logic [LETTER_W-1:0] tmp;
    push_beat(OP_CLEAR, 5'd0);
    for (k = 0; k < WRAP_PAT_LEN; k++) begin
      pat = {pat, 5'($urandom_range(0, 2))};
      push_beat(OP_PATTERN, pat[k]);
    end
    j = 0;
    while (j < MAX_PATTERN + 16) begin
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 7) == 0) push_beat(OP_TEXT, 5'($urandom_range(26, 31)));
        else push_beat(OP_TEXT, 5'($urandom_range(0, 3)));
        j++;
      end else begin
        perm = pat;
        for (k = perm.size() - 1; k > 0; k--) begin
          swap_at = $urandom_range(0, k);
          tmp = perm[k];
          perm[k] = perm[swap_at];
          perm[swap_at] = tmp;
        end
        foreach (perm[i]) push_beat(OP_TEXT, perm[i]);
        j += WRAP_PAT_LEN;
      end
    end
  endfunction

  function automatic void build_random_traffic(input int budget);
    int base, plen, tlen, k, j, roll, swap_at, alpha;
    logic [LETTER_W-1:0] pat[$];
    logic [LETTER_W-1:0] perm[$];
    logic [LETTER_W-1:0] tmp;
    base = pending_beats.size();
    while (pending_beats.size() - base < budget) begin
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 8))
          push_beat(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)));
        continue;
      end
      alpha = ($urandom_range(0, 2) == 0) ? ALPHABET : $urandom_range(1, 4);
      case ($urandom_range(0, 9))
        0: plen = 0;
        1: plen = $urandom_range(10, 40);
        default: plen = $urandom_range(1, 6);
      endcase
      // now and then skip the clear, so the pattern letters land late
      if ($urandom_range(0, 9) != 0) push_beat(OP_CLEAR, 5'($urandom_range(0, 31)));
      pat.delete();
      for (k = 0; k < plen; k++) begin
        pat = {pat, 5'($urandom_range(0, alpha - 1))};
        push_beat(OP_PATTERN, pat[k]);
        if ($urandom_range(0, 15) == 0) push_beat(OP_PATTERN, 5'($urandom_range(26, 31)));
      end
      tlen = $urandom_range(5, 60);
      j = 0;
      while (j < tlen) begin
        roll = $urandom_range(0, 9);
        if (roll < 4 && plen > 0) begin
          perm = pat;
          for (k = perm.size() - 1; k > 0; k--) begin
            swap_at = $urandom_range(0, k);
            tmp = perm[k];
            perm[k] = perm[swap_at];
            perm[swap_at] = tmp;
          end
          foreach (perm[i]) push_beat(OP_TEXT, perm[i]);
          j += plen;
        end else if (roll == 4) begin
          push_beat(OP_TEXT, 5'($urandom_range(26, 31)));
          j++;
        end else if (roll == 5) begin
          push_beat(OP_PATTERN, 5'($urandom_range(0, 31)));
        end else if (roll == 6) begin
          push_beat(OP_UNUSED, 5'($urandom_range(0, 31)));
        end else begin
          push_beat(OP_TEXT, 5'($urandom_range(0, alpha - 1)));
          j++;
        end
      end
    end
  endfunction

  // sender
  int src_gap  = 0;
  int src_mode = 1;
  bit wind_down = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        anagram_predict(on_bus);
        beats_taken++;
      end
      if ($urandom_range(0, 99) == 0) src_mode = $urandom_range(0, 2);
      wind_down <= (pending_beats.size() < 400);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          on_bus = pending_beats.pop_front();
          s_axis_tdata  <= {1'b0, on_bus.letter, on_bus.op};
          s_axis_tvalid <= 1'b1;
          if (!wind_down && src_mode != 0 &&
              $urandom_range(0, (src_mode == 1) ? 15 : 3) == 0)
            src_gap = $urandom_range(1, 18);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  int sink_gap  = 0;
  int sink_mode = 1;
  bit long_hold_done = 1'b0;

  always @(posedge clk) begin
    window_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_windows.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $error("result beat with nothing expected: tdata 0x%06h", m_axis_tdata);
        end else begin
          want = expected_windows.pop_front();
          if (m_axis_tdata[0] !== want.match) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $error("match: expected %0d, got %0d", want.match, m_axis_tdata[0]);
          end
          if (m_axis_tdata[16:1] !== want.start_index) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $error("start_index: expected %0d, got %0d", want.start_index,
                     m_axis_tdata[16:1]);
          end
          if (want.match) matches_seen++;
        end
      end
      if ($urandom_range(0, 99) == 0) sink_mode = $urandom_range(0, 2);
      // one long back-pressure stretch so the input side stalls
      if (!long_hold_done && results_seen >= 300) begin
        long_hold_done = 1'b1;
        sink_gap = 500;
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!wind_down && sink_mode != 0 &&
            $urandom_range(0, (sink_mode == 1) ? 15 : 3) == 0)
          sink_gap = $urandom_range(1, 18);
      end
    end
  end

  initial begin
    foreach (tally[i]) tally[i] = 0;
    pat_len = 0;
    distinct = 0;
    satisfied = 0;
    fill = 0;
    win_start = 0;
    wr_ptr = 0;
    text_seen = 1'b0;
    build_directed();
    build_ring_wrap();
    build_random_traffic(300);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    do @(negedge clk);
    while (pending_beats.size() != 0 || s_axis_tvalid || expected_windows.size() != 0);
    repeat (20) @(negedge clk);
    $display("Run covered %0d input beats and %0d result beats: %0d matching windows,",
             beats_taken, results_seen, matches_seen);
    $display("  a ring wrap past full depth and one long output stall; %0d failures.",
             fail_count);
    if (fail_count == 0) begin
      $display("** sliding_window_anagram_finder: PASSED **");
    end else begin
      $display("** sliding_window_anagram_finder: FAILED **");
    end
    $finish;
  end

  initial begin
    #(30_000_000);
    $display("** sliding_window_anagram_finder: FAILED **");
    $finish;
  end

endmodule
